>>> hw/rtl/jtg_pkg.sv
// ----------------------------------------------------------------------------
// jtg_pkg
// Shared types, constants and the control store of the Julian to Gregorian
// date converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jtg_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int OFF_W   = 8;
    localparam int PC_W    = 4;

    // floor(x / 100) == (x * 5243) >> 19 for every 14-bit x
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = 27;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam logic [6:0] CENTURY = 7'd100;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W:0]   MONTH_MAX = 5'd12;
    localparam logic [DAY_W-1:0]   LEAP_DAY  = 5'd29;
    localparam logic [DAY_W-1:0]   FIRST_DAY = 5'd1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // take the input word
        OP_MUL_PREV,  // q <= (year - 1) / 100
        OP_CENT,      // off <= centuries not divisible by 400
        OP_MUL_YEAR,  // q <= year / 100
        OP_ADJ,       // late-date correction, minus one, leap flag
        OP_LEAP,      // leap flag only
        OP_DAY,       // advance one day
        OP_EMIT       // load output register
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_OFF_ZERO,
        C_NO_CARRY,
        C_OUT_BUSY,
        C_OUT_FREE
    } cond_t;

    // next pc: jcond ? target : (scond ? pc : pc + 1)
    typedef struct packed {
        op_t              op;
        cond_t            jcond;
        cond_t            scond;
        logic [PC_W-1:0]  target;
    } ctrl_word_t;

    localparam logic [PC_W-1:0] STEP_IDLE = 4'd0;
    localparam logic [PC_W-1:0] STEP_DAY  = 4'd5;
    localparam logic [PC_W-1:0] STEP_EMIT = 4'd8;

    function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = '{op: OP_NONE, jcond: C_ALWAYS, scond: C_NEVER, target: STEP_IDLE};
        case (pc)
            4'd0: w = '{op: OP_LOAD,     jcond: C_NEVER,    scond: C_NO_IN,
                        target: STEP_IDLE};
            4'd1: w = '{op: OP_MUL_PREV, jcond: C_NEVER,    scond: C_NEVER,
                        target: STEP_IDLE};
            4'd2: w = '{op: OP_CENT,     jcond: C_NEVER,    scond: C_NEVER,
                        target: STEP_IDLE};
            4'd3: w = '{op: OP_MUL_YEAR, jcond: C_NEVER,    scond: C_NEVER,
                        target: STEP_IDLE};
            4'd4: w = '{op: OP_ADJ,      jcond: C_NEVER,    scond: C_NEVER,
                        target: STEP_IDLE};
            4'd5: w = '{op: OP_DAY,      jcond: C_OFF_ZERO, scond: C_NO_CARRY,
                        target: STEP_EMIT};
            4'd6: w = '{op: OP_MUL_YEAR, jcond: C_NEVER,    scond: C_NEVER,
                        target: STEP_IDLE};
            4'd7: w = '{op: OP_LEAP,     jcond: C_ALWAYS,   scond: C_NEVER,
                        target: STEP_DAY};
            4'd8: w = '{op: OP_EMIT,     jcond: C_OUT_FREE, scond: C_OUT_BUSY,
                        target: STEP_IDLE};
            default: w = '{op: OP_NONE,  jcond: C_ALWAYS,   scond: C_NEVER,
                           target: STEP_IDLE};
        endcase
        return w;
    endfunction

    // Gregorian month length; months outside 1..12 have length zero
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mo,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (mo) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/julian_to_gregorian_date.sv
// ----------------------------------------------------------------------------
// julian_to_gregorian_date
// Converts a Julian calendar date to the same day in the Gregorian calendar.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one word: julian_year,
//   julian_month, julian_day. Output channel (out_valid/out_ready) returns
//   one word per input: greg_year, greg_month, greg_day.
//   A small microcoded sequencer runs each word: a step counter reads a
//   control word from a ROM that drives one shared 14x13 multiplier (for
//   /100 by reciprocal) and a day-advance unit.
//   The day loop advances the date by offset days, where offset = centuries
//   below the year not divisible by 400, minus one, plus one for a date past
//   February 28 in such a century year (74 for year 9999). It advances one
//   day per cycle, but a year carry detours through the year and leap steps.
//   One word is in work at a time; in_ready is high only at the idle step,
//   so a new word is taken only after the last has left the emit step.
//   The result sits in an output register; the next word is accepted while
//   it waits, and the sequencer only holds at its final step if the
//   previous result has not yet been taken.
//   Reset (rst_n low, asynchronous) returns the sequencer to idle and drops
//   out_valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module julian_to_gregorian_date (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire  [jtg_pkg::YEAR_W-1:0]       julian_year,
    input  wire  [jtg_pkg::MONTH_W-1:0]      julian_month,
    input  wire  [jtg_pkg::DAY_W-1:0]        julian_day,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [jtg_pkg::YEAR_W-1:0]       greg_year,
    output logic [jtg_pkg::MONTH_W-1:0]      greg_month,
    output logic [jtg_pkg::DAY_W-1:0]        greg_day
);

    localparam int YW = jtg_pkg::YEAR_W;
    localparam int MW = jtg_pkg::MONTH_W;
    localparam int DW = jtg_pkg::DAY_W;
    localparam int OW = jtg_pkg::OFF_W;
    localparam int PW = jtg_pkg::PC_W;

    // sequencer
    logic [PW-1:0]        pc_reg, pc_next;
    jtg_pkg::ctrl_word_t  ctrl;
    logic                 jump, stay;

    // datapath
    logic [YW-1:0]  yr_reg, yr_next;
    logic [MW-1:0]  mo_reg, mo_next;
    logic [DW-1:0]  dd_reg, dd_next;
    logic [OW-1:0]  off_reg, off_next;
    logic [OW-1:0]  q_reg, q_next;
    logic           leap_reg, leap_next;
    logic           out_valid_reg, out_valid_next;
    logic [YW-1:0]  oy_reg, oy_next;
    logic [MW-1:0]  om_reg, om_next;
    logic [DW-1:0]  od_reg, od_next;

    logic [YW-1:0]  mul_a;
    logic [jtg_pkg::PROD_W-1:0] prod;
    logic           cent_hit, leap_now, late_date, adj;
    logic [OW:0]    adj_sum;
    logic [DW-1:0]  len;
    logic [DW:0]    day_inc;
    logic [MW:0]    mo_step;
    logic           roll, carry, off_zero, out_free;

    assign ctrl     = jtg_pkg::ucode(pc_reg);
    assign off_zero = (off_reg == '0);
    assign out_free = !out_valid_reg || out_ready;

    // shared reciprocal multiplier
    assign mul_a = (ctrl.op == jtg_pkg::OP_MUL_PREV) ? yr_reg - YW'(1) : yr_reg;
    assign prod  = jtg_pkg::PROD_W'(mul_a) * jtg_pkg::PROD_W'(jtg_pkg::RECIP_100);

    // q_reg holds year / 100 during the adjust and leap steps
    assign cent_hit  = ({1'b0, yr_reg} == (YW+1)'(q_reg) * (YW+1)'(jtg_pkg::CENTURY));
    assign leap_now  = cent_hit ? (q_reg[1:0] == 2'd0) : (yr_reg[1:0] == 2'd0);
    assign late_date = (mo_reg > jtg_pkg::MONTH_FEB) ||
                       (mo_reg == jtg_pkg::MONTH_FEB && dd_reg == jtg_pkg::LEAP_DAY);
    assign adj       = cent_hit && (q_reg[1:0] != 2'd0) && late_date;
    assign adj_sum   = {1'b0, off_reg} + (OW+1)'(adj);

    // one-day advance
    assign len     = jtg_pkg::month_len(mo_reg, leap_reg);
    assign day_inc = {1'b0, dd_reg} + (DW+1)'(1);
    assign roll    = day_inc > {1'b0, len};
    assign mo_step = roll ? {1'b0, mo_reg} + (MW+1)'(1) : {1'b0, mo_reg};
    assign carry   = mo_step > jtg_pkg::MONTH_MAX;

    function automatic logic cond_true(input jtg_pkg::cond_t c, input logic inv,
                                       input logic offz, input logic cy,
                                       input logic ofree);
        logic r;
        case (c)
            jtg_pkg::C_NEVER:    r = 1'b0;
            jtg_pkg::C_ALWAYS:   r = 1'b1;
            jtg_pkg::C_NO_IN:    r = !inv;
            jtg_pkg::C_OFF_ZERO: r = offz;
            jtg_pkg::C_NO_CARRY: r = !cy;
            jtg_pkg::C_OUT_BUSY: r = !ofree;
            jtg_pkg::C_OUT_FREE: r = ofree;
            default:             r = 1'b0;
        endcase
        return r;
    endfunction

    assign jump = cond_true(ctrl.jcond, in_valid, off_zero, carry, out_free);
    assign stay = cond_true(ctrl.scond, in_valid, off_zero, carry, out_free);

    always_comb
    begin
        pc_next        = jump ? ctrl.target : (stay ? pc_reg : pc_reg + PW'(1));
        in_ready       = (ctrl.op == jtg_pkg::OP_LOAD);
        yr_next        = yr_reg;
        mo_next        = mo_reg;
        dd_next        = dd_reg;
        off_next       = off_reg;
        q_next         = q_reg;
        leap_next      = leap_reg;
        oy_next        = oy_reg;
        om_next        = om_reg;
        od_next        = od_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (ctrl.op)
            jtg_pkg::OP_LOAD:
            begin
                if (in_valid)
                begin
                    yr_next = julian_year;
                    mo_next = julian_month;
                    dd_next = julian_day;
                end
            end
            jtg_pkg::OP_MUL_PREV, jtg_pkg::OP_MUL_YEAR:
            begin
                q_next = prod[jtg_pkg::RECIP_SHIFT +: OW];
            end
            jtg_pkg::OP_CENT:
            begin
                // year zero has no offset; the wrapped year - 1 is ignored
                off_next = (yr_reg == '0) ? '0 : q_reg - {2'b00, q_reg[OW-1:2]};
            end
            jtg_pkg::OP_ADJ:
            begin
                off_next  = (adj_sum == '0) ? '0 : OW'(adj_sum - (OW+1)'(1));
                leap_next = leap_now;
            end
            jtg_pkg::OP_LEAP:
            begin
                leap_next = leap_now;
            end
            jtg_pkg::OP_DAY:
            begin
                if (!off_zero)
                begin
                    off_next = off_reg - OW'(1);
                    dd_next  = roll ? jtg_pkg::FIRST_DAY : day_inc[DW-1:0];
                    mo_next  = carry ? jtg_pkg::MONTH_JAN : mo_step[MW-1:0];
                    yr_next  = carry ? yr_reg + YW'(1) : yr_reg;
                end
            end
            jtg_pkg::OP_EMIT:
            begin
                if (out_free)
                begin
                    oy_next        = yr_reg;
                    om_next        = mo_reg;
                    od_next        = dd_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= jtg_pkg::STEP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        yr_reg   <= yr_next;
        mo_reg   <= mo_next;
        dd_reg   <= dd_next;
        off_reg  <= off_next;
        q_reg    <= q_next;
        leap_reg <= leap_next;
        oy_reg   <= oy_next;
        om_reg   <= om_next;
        od_reg   <= od_next;
    end

    assign out_valid  = out_valid_reg;
    assign greg_year  = oy_reg;
    assign greg_month = om_reg;
    assign greg_day   = od_reg;

`ifndef SYNTHESIS
    // a real day step always leaves a day in 1..31 and a month in 1..12
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == jtg_pkg::OP_DAY && !off_zero) |=> (dd_reg != '0))
        else $error("day register zero after day step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == jtg_pkg::OP_DAY && !off_zero) |=>
            (mo_reg != '0 && {1'b0, mo_reg} <= jtg_pkg::MONTH_MAX))
        else $error("month out of range after day step");

    // the loop leaves the day step only once the offset is used up
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == jtg_pkg::OP_DAY && pc_next == jtg_pkg::STEP_EMIT) |-> off_zero)
        else $error("day loop left with offset remaining");

    // an unaccepted result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> ($stable(oy_reg) && $stable(om_reg)
                                           && $stable(od_reg)))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
